FILE: hw/rtl/ppte_pkg.sv
// Shared types, constants and helper functions for the PPM P3 text encoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package ppte_pkg;

  localparam int LEVEL_W  = 16;
  localparam int CFG_W    = 12;
  localparam int COUNT_W  = 24;
  localparam int CHAR_W   = 8;
  localparam int HDR_MAX  = 17;
  localparam int BODY_MAX = 12;
  localparam int NUM_LANES = 3;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
  localparam logic [CHAR_W-1:0] CH_3     = 8'h33;
  localparam logic [CHAR_W-1:0] CH_2     = 8'h32;
  localparam logic [CHAR_W-1:0] CH_5     = 8'h35;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;

  // decimal text of one channel value, first digit in chr[0]
  typedef struct packed {
    logic [1:0]              len;
    logic [2:0][CHAR_W-1:0]  chr;
  } lane_text_t;

  typedef struct packed {
    logic [3:0]                     len;
    logic [BODY_MAX-1:0][CHAR_W-1:0] chr;
  } body_text_t;

  typedef struct packed {
    logic [4:0]                    len;
    logic [HDR_MAX-1:0][CHAR_W-1:0] chr;
  } hdr_text_t;

  // digits of a header number, d[3] is thousands
  typedef struct packed {
    logic [3:0][3:0] d;
  } dec4_t;

  typedef struct packed {
    logic hdr;
    logic last;
  } pixel_job_t;

  typedef struct packed {
    logic en_a;
    logic en_b;
  } pipe_ctrl_t;

  function automatic logic [3:0] digit_of(input logic [CFG_W-1:0] value,
                                          input logic [CFG_W-1:0] weight);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({4'd0, value} >= 16'(k) * {4'd0, weight}) d = 4'(k);
    end
    return d;
  endfunction

  function automatic lane_text_t to_text3(input logic [7:0] v);
    lane_text_t t;
    logic [1:0] h;
    logic [7:0] r;
    logic [3:0] te;
    logic [3:0] on;
    if (v >= 8'd200) begin
      h = 2'd2;
      r = v - 8'd200;
    end else if (v >= 8'd100) begin
      h = 2'd1;
      r = v - 8'd100;
    end else begin
      h = 2'd0;
      r = v;
    end
    te = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 8'(k * 10)) te = 4'(k);
    end
    on = 4'(r - 8'(te) * 8'd10);
    t.chr = '0;
    if (h != 2'd0) begin
      t.len    = 2'd3;
      t.chr[0] = CH_ZERO + {6'd0, h};
      t.chr[1] = CH_ZERO + {4'd0, te};
      t.chr[2] = CH_ZERO + {4'd0, on};
    end else if (te != 4'd0) begin
      t.len    = 2'd2;
      t.chr[0] = CH_ZERO + {4'd0, te};
      t.chr[1] = CH_ZERO + {4'd0, on};
    end else begin
      t.len    = 2'd1;
      t.chr[0] = CH_ZERO + {4'd0, on};
    end
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ppte_lane.sv
// One channel lane: scale a fixed-point level to 0..255, then split it into
// decimal characters. Two register stages. Depends on ppte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppte_lane import ppte_pkg::*; #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                      clk,
  input  wire pipe_ctrl_t                ctrl,
  input  wire logic signed [LEVEL_W-1:0] level,
  output lane_text_t                     text_r
);

  localparam int PROD_W = LEVEL_W + 8;

  logic [7:0]        byte_r;
  logic [7:0]        byte_nxt;
  logic [PROD_W-1:0] x;
  logic [PROD_W-1:0] sum;
  logic [PROD_W-1:0] scaled;

  always_comb begin
    x      = {{(PROD_W-LEVEL_W+1){1'b0}}, level[LEVEL_W-2:0]};
    sum    = (x << 8) - x + (PROD_W'(1) << (FRAC_BITS - 1));
    scaled = sum >> FRAC_BITS;
    if (level[LEVEL_W-1]) begin
      byte_nxt = 8'd0;
    end else if (|scaled[PROD_W-1:8]) begin
      byte_nxt = 8'd255;
    end else begin
      byte_nxt = scaled[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_a) byte_r <= byte_nxt;
    if (ctrl.en_b) text_r <= to_text3(byte_r);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppte_merge.sv
// Merge stage: join the three lane texts into one pixel line with spaces and
// a closing newline. Depends on ppte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppte_merge import ppte_pkg::*; (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire lane_text_t lanes [NUM_LANES],
  output body_text_t      body_r
);

  body_text_t body_nxt;

  always_comb begin
    logic [3:0] ptr;
    ptr = 4'd0;
    body_nxt.chr = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < lanes[c].len) body_nxt.chr[ptr + 4'(k)] = lanes[c].chr[k];
      end
      body_nxt.chr[ptr + {2'd0, lanes[c].len}] = (c == NUM_LANES - 1) ? CH_LF : CH_SPACE;
      ptr = ptr + {2'd0, lanes[c].len} + 4'd1;
    end
    body_nxt.len = ptr;
  end

  always_ff @(posedge clk) begin
    if (en) body_r <= body_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppte_hdr.sv
// Header text builder: converts width and height to decimal over three
// stages and assembles the P3 header line set. Depends on ppte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppte_hdr import ppte_pkg::*; (
  input  wire logic             clk,
  input  wire logic [CFG_W-1:0] frame_width,
  input  wire logic [CFG_W-1:0] frame_height,
  output hdr_text_t             hdr_r
);

  logic [CFG_W-1:0] num [2];
  logic [CFG_W-1:0] rem1_r [2];
  logic [CFG_W-1:0] rem2_r [2];
  dec4_t            s1_r [2];
  dec4_t            s2_r [2];
  dec4_t            s3_r [2];
  hdr_text_t        hdr_nxt;

  assign num[0] = frame_width;
  assign num[1] = frame_height;

  always_ff @(posedge clk) begin
    for (int n = 0; n < 2; n++) begin
      s1_r[n]   <= {digit_of(num[n], 12'd1000), 12'd0};
      rem1_r[n] <= num[n] - 12'(digit_of(num[n], 12'd1000) * 12'd1000);
      s2_r[n]   <= {s1_r[n].d[3], digit_of(rem1_r[n], 12'd100), 8'd0};
      rem2_r[n] <= rem1_r[n] - 12'(digit_of(rem1_r[n], 12'd100) * 12'd100);
      s3_r[n]   <= {s2_r[n].d[3], s2_r[n].d[2], digit_of(rem2_r[n], 12'd10),
                    4'(rem2_r[n] - 12'(digit_of(rem2_r[n], 12'd10) * 12'd10))};
    end
    hdr_r <= hdr_nxt;
  end

  always_comb begin
    logic [4:0] ptr;
    logic [2:0] len;
    hdr_nxt.chr    = '0;
    hdr_nxt.chr[0] = CH_P;
    hdr_nxt.chr[1] = CH_3;
    hdr_nxt.chr[2] = CH_LF;
    ptr = 5'd3;
    for (int n = 0; n < 2; n++) begin
      if (s3_r[n].d[3] != 4'd0) begin
        len = 3'd4;
      end else if (s3_r[n].d[2] != 4'd0) begin
        len = 3'd3;
      end else if (s3_r[n].d[1] != 4'd0) begin
        len = 3'd2;
      end else begin
        len = 3'd1;
      end
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < len) begin
          hdr_nxt.chr[ptr + 5'(k)] = CH_ZERO + {4'd0, s3_r[n].d[2'(len - 3'd1 - 3'(k))]};
        end
      end
      hdr_nxt.chr[ptr + {2'd0, len}] = (n == 0) ? CH_SPACE : CH_LF;
      ptr = ptr + {2'd0, len} + 5'd1;
    end
    hdr_nxt.chr[ptr]        = CH_2;
    hdr_nxt.chr[ptr + 5'd1] = CH_5;
    hdr_nxt.chr[ptr + 5'd2] = CH_5;
    hdr_nxt.chr[ptr + 5'd3] = CH_LF;
    hdr_nxt.len = ptr + 5'd4;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppte_serial.sv
// Output serializer: holds one pixel's text (optionally preceded by the
// header) and sends it one character per transaction. Depends on ppte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppte_serial import ppte_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_valid,
  input  wire pixel_job_t        load_job,
  input  wire hdr_text_t         load_hdr,
  input  wire body_text_t        load_body,
  output logic                   load_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [CHAR_W-1:0]      out_char_code,
  output logic                   out_last_of_pixel,
  output logic                   out_last_of_frame
);

  logic       busy_r;
  logic       busy_nxt;
  logic [4:0] idx_r;
  logic [4:0] idx_nxt;
  logic [4:0] hlen_r;
  logic [4:0] tlen_r;
  logic       last_r;
  hdr_text_t  hdr_r;
  body_text_t body_r;
  logic       final_char;
  logic       take;
  logic       load;
  logic [4:0] bidx;

  assign final_char = (idx_r == tlen_r - 5'd1);
  assign take       = busy_r && out_ready;
  assign load_ready = !busy_r || (out_ready && final_char);
  assign load       = load_valid && load_ready;
  assign bidx       = idx_r - hlen_r;

  assign out_valid         = busy_r;
  assign out_char_code     = (idx_r < hlen_r) ? hdr_r.chr[idx_r] : body_r.chr[bidx[3:0]];
  assign out_last_of_pixel = final_char;
  assign out_last_of_frame = final_char && last_r;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 5'd0;
    end else if (take) begin
      if (final_char) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
    if (load) begin
      hdr_r  <= load_hdr;
      body_r <= load_body;
      last_r <= load_job.last;
      hlen_r <= load_job.hdr ? load_hdr.len : 5'd0;
      tlen_r <= (load_job.hdr ? load_hdr.len : 5'd0) + {1'b0, load_body.len};
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_to_ppm_text_encoder_top.sv
// Top level of the PPM P3 text encoder: configuration registers, pixel
// counter, three channel lanes, merge stage and serializer. Uses ppte_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted pixel yields its P3 text as one 8-bit character per output
// transaction: 6 to 12 characters for the three values, spaces and newline,
// plus 11 to 17 header characters on the first pixel of a frame. The output
// serializer sends one character per cycle while out_ready is high, and the
// lanes and merge stage take the next pixel meanwhile. The first character
// appears once the pixel has passed the lane byte and text registers, the
// merge register and the serializer load. Width and height take effect for
// the frame length at once and reach the header text through the three
// conversion stages and the header register; the input holds off after a
// write and after reset, so the next pixel's header already carries them.
module pixel_to_ppm_text_encoder_top import ppte_pkg::*; #(
  parameter int CHANNEL_FRAC_BITS = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [LEVEL_W-1:0] in_red_level,
  input  wire logic signed [LEVEL_W-1:0] in_green_level,
  input  wire logic signed [LEVEL_W-1:0] in_blue_level,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [CHAR_W-1:0]              out_char_code,
  output logic                           out_last_of_pixel,
  output logic                           out_last_of_frame
);

  logic [CFG_W-1:0]   width_r;
  logic [CFG_W-1:0]   height_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [COUNT_W-1:0] total;
  logic               last;
  logic               in_accept;
  logic               cfg_hold_r;

  logic       va_r, vb_r, vc_r;
  logic       va_nxt, vb_nxt, vc_nxt;
  pixel_job_t job_a_r, job_b_r, job_c_r;
  pixel_job_t job_in;
  pipe_ctrl_t ctrl;
  logic       en_c;
  logic       ser_ready;

  logic signed [LEVEL_W-1:0] levels [NUM_LANES];
  lane_text_t                lane_text [NUM_LANES];
  body_text_t                body;
  hdr_text_t                 hdr;

  assign levels[0] = in_red_level;
  assign levels[1] = in_green_level;
  assign levels[2] = in_blue_level;

  assign en_c      = !vc_r || ser_ready;
  assign ctrl.en_b = !vb_r || en_c;
  assign ctrl.en_a = !va_r || ctrl.en_b;
  assign in_ready  = ctrl.en_a && !cfg_hold_r;
  assign in_accept = in_valid && in_ready;

  assign total      = COUNT_W'(width_r) * COUNT_W'(height_r);
  assign last       = ({1'b0, count_r} + 25'd1) >= {1'b0, total};
  assign job_in.hdr  = (count_r == '0);
  assign job_in.last = last;

  always_comb begin
    count_nxt = count_r;
    if (in_accept) count_nxt = last ? '0 : count_r + COUNT_W'(1);
    va_nxt = ctrl.en_a ? in_accept : va_r;
    vb_nxt = ctrl.en_b ? va_r : vb_r;
    vc_nxt = en_c ? vb_r : vc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= FRAME_WIDTH_RESET;
      height_r   <= FRAME_HEIGHT_RESET;
      count_r    <= '0;
      va_r       <= 1'b0;
      vb_r       <= 1'b0;
      vc_r       <= 1'b0;
      cfg_hold_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
          REG_FRAME_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
      count_r    <= count_nxt;
      va_r       <= va_nxt;
      vb_r       <= vb_nxt;
      vc_r       <= vc_nxt;
      cfg_hold_r <= cfg_we;
    end
    if (ctrl.en_a) job_a_r <= job_in;
    if (ctrl.en_b) job_b_r <= job_a_r;
    if (en_c)      job_c_r <= job_b_r;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    ppte_lane #(
      .FRAC_BITS (CHANNEL_FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .level  (levels[g]),
      .text_r (lane_text[g])
    );
  end

  ppte_merge u_merge (
    .clk    (clk),
    .en     (en_c),
    .lanes  (lane_text),
    .body_r (body)
  );

  ppte_hdr u_hdr (
    .clk          (clk),
    .frame_width  (width_r),
    .frame_height (height_r),
    .hdr_r        (hdr)
  );

  ppte_serial u_serial (
    .clk               (clk),
    .rst_n             (rst_n),
    .load_valid        (vc_r),
    .load_job          (job_c_r),
    .load_hdr          (hdr),
    .load_body         (body),
    .load_ready        (ser_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_char_code     (out_char_code),
    .out_last_of_pixel (out_last_of_pixel),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

`default_nettype wire
